@@ src/sliding_median_filter_unit_defines.svh @@
// Assertion macros for the sliding median filter.
// Included by sliding_median_filter_unit.sv; expects clk and rst_n in scope.
`ifndef SLIDING_MEDIAN_FILTER_UNIT_DEFINES_SVH
`define SLIDING_MEDIAN_FILTER_UNIT_DEFINES_SVH

// same-cycle implication
`define SMF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/smf_pkg.sv @@
// Shared types, constants and ring helpers for the sliding median filter.
// No dependencies.
package smf_pkg;

    localparam int WINDOW_DEPTH = 128;
    localparam int SAMPLE_BITS  = 16;

    localparam int POS_W   = 32;
    localparam int THICK_W = 16;
    localparam int CFG_W   = 6;

    localparam int MAX_HALF = (WINDOW_DEPTH - 1) / 2;
    localparam int IDX_W    = $clog2(WINDOW_DEPTH);
    localparam int FILL_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int HALF_W   = $clog2(MAX_HALF + 1);
    localparam int LEN_W    = HALF_W + 1;
    localparam int SUM_W    = FILL_W + 1;

    localparam logic [CFG_W-1:0] HALF_RESET = CFG_W'(10);

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [FILL_W-1:0]      fill_t;
    typedef logic [HALF_W-1:0]      half_t;
    typedef logic [LEN_W-1:0]       len_t;

    localparam sample_t SAMPLE_MSB = sample_t'(1) << (SAMPLE_BITS - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_LAST = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    function automatic idx_t ring_inc(input idx_t ptr);
        idx_t r;
        if (int'(ptr) == WINDOW_DEPTH - 1)
            r = '0;
        else
            r = ptr + idx_t'(1);
        return r;
    endfunction

    // ptr minus amt, modulo the ring depth; amt never exceeds the depth
    function automatic idx_t ring_sub(input idx_t ptr, input fill_t amt);
        logic [SUM_W-1:0] p;
        logic [SUM_W-1:0] a;
        logic [SUM_W-1:0] r;
        p = SUM_W'(ptr);
        a = SUM_W'(amt);
        if (p >= a)
            r = p - a;
        else
            r = p + SUM_W'(WINDOW_DEPTH) - a;
        return IDX_W'(r);
    endfunction

endpackage

@@ src/sliding_median_filter_unit.sv @@
// A beat that fills the window of L = 2*h+1 samples gives its result after one bit-serial
// count pass over the sample RAM per thickness bit (one shared comparator, one read per cycle),
// then the position read and the load of the output register, which waits for out_ready.
// Such a beat holds in_ready low until its result is loaded; a beat with no result leaves
// the unit idle and ready. Reset clears control and sets half_window to 10; stores are not cleared.
// Depends on smf_pkg, smf_ram and sliding_median_filter_unit_defines.svh.
`include "sliding_median_filter_unit_defines.svh"

module sliding_median_filter_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [smf_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [smf_pkg::POS_W-1:0]     position,
    input  logic [smf_pkg::THICK_W-1:0]   thickness,
    input  logic                          first_of_set,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [smf_pkg::POS_W-1:0]     center_position,
    output logic [smf_pkg::THICK_W-1:0]   median_thickness
);

    import smf_pkg::*;

    state_t                 state_reg, state_next;
    logic [CFG_W-1:0]       half_window_reg;
    idx_t                   wp_reg, wp_next;
    fill_t                  fill_count_reg, fill_count_next;
    fill_t                  fill_base;
    half_t                  h_reg, h_next, h_eff;
    len_t                   len_reg, len_next, len_eff;
    idx_t                   base_reg, base_next;
    idx_t                   rd_addr_reg, rd_addr_next;
    len_t                   iss_reg, iss_next;
    len_t                   cnt_reg, cnt_next;
    len_t                   cnt_total;
    logic                   rd_valid_reg;
    sample_t                ans_reg, ans_next;
    sample_t                bit_reg, bit_next;
    sample_t                cand;
    sample_t                sample_rd;
    logic                   lt;
    logic [POS_W-1:0]       pos_rd;
    logic                   pos_rd_en;
    idx_t                   center_addr;
    logic                   accept;
    logic                   out_load;
    logic                   out_valid_reg;
    logic [POS_W-1:0]       center_position_reg;
    logic [THICK_W-1:0]     median_reg;

    assign accept      = in_valid && in_ready;
    assign in_ready    = (state_reg == S_IDLE);
    assign cand        = ans_reg | bit_reg;
    assign lt          = (sample_rd < cand);
    assign cnt_total   = cnt_reg + len_t'(lt);
    assign center_addr = ring_sub(wp_reg, fill_t'(h_reg) + fill_t'(1));
    assign pos_rd_en   = (state_reg == S_LAST) && bit_reg[0];
    assign out_load    = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    assign out_valid        = out_valid_reg;
    assign center_position  = center_position_reg;
    assign median_thickness = median_reg;

    always_comb
    begin
        if (int'(half_window_reg) > MAX_HALF)
            h_eff = half_t'(MAX_HALF);
        else
            h_eff = half_t'(half_window_reg);
        len_eff = {h_eff, 1'b1};
    end

    smf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_DEPTH)
    ) u_sample_ram (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (wp_reg),
        .wr_data (SAMPLE_BITS'(thickness)),
        .rd_en   (state_reg == S_SCAN),
        .rd_addr (rd_addr_reg),
        .rd_data (sample_rd)
    );

    smf_ram #(
        .WIDTH (POS_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_position_ram (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (wp_reg),
        .wr_data (position),
        .rd_en   (pos_rd_en),
        .rd_addr (center_addr),
        .rd_data (pos_rd)
    );

    always_comb
    begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        fill_count_next = fill_count_reg;
        fill_base       = first_of_set ? '0 : fill_count_reg;
        h_next          = h_reg;
        len_next        = len_reg;
        base_next       = base_reg;
        rd_addr_next    = rd_addr_reg;
        iss_next        = iss_reg;
        cnt_next        = cnt_reg;
        ans_next        = ans_reg;
        bit_next        = bit_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (int'(fill_base) < WINDOW_DEPTH)
                        fill_count_next = fill_base + fill_t'(1);
                    else
                        fill_count_next = fill_base;
                    wp_next      = ring_inc(wp_reg);
                    h_next       = h_eff;
                    len_next     = len_eff;
                    base_next    = ring_sub(ring_inc(wp_reg), fill_t'(len_eff));
                    rd_addr_next = ring_sub(ring_inc(wp_reg), fill_t'(len_eff));
                    iss_next     = '0;
                    cnt_next     = '0;
                    ans_next     = '0;
                    bit_next     = SAMPLE_MSB;
                    if (fill_count_next >= fill_t'(len_eff))
                        state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                iss_next     = iss_reg + len_t'(1);
                rd_addr_next = ring_inc(rd_addr_reg);
                if (rd_valid_reg && lt)
                    cnt_next = cnt_reg + len_t'(1);
                if (iss_reg == len_reg - len_t'(1))
                    state_next = S_LAST;
            end
            S_LAST:
            begin
                if (cnt_total <= len_t'(h_reg))
                    ans_next = cand;
                iss_next     = '0;
                cnt_next     = '0;
                rd_addr_next = base_reg;
                if (bit_reg[0])
                begin
                    bit_next   = SAMPLE_MSB;
                    state_next = S_DONE;
                end
                else
                begin
                    bit_next   = bit_reg >> 1;
                    state_next = S_SCAN;
                end
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            half_window_reg <= HALF_RESET;
            wp_reg          <= '0;
            fill_count_reg  <= '0;
            h_reg           <= '0;
            len_reg         <= len_t'(1);
            base_reg        <= '0;
            rd_addr_reg     <= '0;
            iss_reg         <= '0;
            cnt_reg         <= '0;
            rd_valid_reg    <= 1'b0;
            ans_reg         <= '0;
            bit_reg         <= SAMPLE_MSB;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_wr_en)
            begin
                half_window_reg <= cfg_wr_data;
            end
            wp_reg         <= wp_next;
            fill_count_reg <= fill_count_next;
            h_reg          <= h_next;
            len_reg        <= len_next;
            base_reg       <= base_next;
            rd_addr_reg    <= rd_addr_next;
            iss_reg        <= iss_next;
            cnt_reg        <= cnt_next;
            rd_valid_reg   <= (state_reg == S_SCAN);
            ans_reg        <= ans_next;
            bit_reg        <= bit_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            center_position_reg <= pos_rd;
            median_reg          <= THICK_W'(ans_reg);
        end
    end

    `SMF_ASSERT_NEXT(a_short_window_stays_idle, accept && (fill_count_next < fill_t'(len_eff)), state_reg == S_IDLE, "beat without full window started a scan")
    `SMF_ASSERT_NOW(a_count_bounded, state_reg == S_SCAN, cnt_reg <= iss_reg, "match count exceeds issued reads")
    `SMF_ASSERT_NOW(a_bit_onehot, state_reg != S_IDLE, $onehot(bit_reg), "bit select not one-hot")
    `SMF_ASSERT_NEXT(a_done_loads_output, out_load, out_valid_reg && (state_reg == S_IDLE), "result not presented after done")

endmodule

@@ src/smf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
